>>> hw/rtl/alld_pkg.sv
// shared types and constants for the affinity least-loaded dispatcher
`default_nettype none
package alld_pkg;

  localparam int unsigned MaxSlots   = 16;
  localparam int unsigned SlotW      = $clog2(MaxSlots);
  localparam int unsigned CountW     = $clog2(MaxSlots + 1);
  localparam int unsigned FilterBits = 256;
  localparam int unsigned HashW      = $clog2(FilterBits);
  localparam int unsigned ScoreW     = 9;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CfgIdxW-1:0] CfgFallback = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPenalty  = 1'd1;

  typedef enum logic [2:0] {
    FuncStatus   = 3'd0,
    FuncDispatch = 3'd1,
    FuncResult   = 3'd2,
    FuncNak      = 3'd3,
    FuncRegister = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    StUnknown = 2'd0,
    StReady   = 2'd1,
    StBusy    = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    ExIdle,
    ExFind,
    ExScan,
    ExResolve,
    ExApply,
    ExOut
  } exec_state_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        node_id;
    logic [HashW-1:0]  hash;
    logic              node_busy;
    logic [7:0]        reported_depth;
    logic              card_in_store;
  } req_t;

  typedef struct packed {
    logic [7:0] dest_node;
    logic       card_pushed;
    logic       slot_found;
    logic       table_full;
  } rsp_t;

  // (major*31 + minor) mod FilterBits
  function automatic logic [HashW-1:0] card_hash(input logic [7:0] major,
                                                 input logic [7:0] minor);
    logic [13:0] sum;
    begin
      sum = 14'(({6'd0, major} << 5) - {6'd0, major}) + 14'(minor);
      card_hash = sum[HashW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/alld_front.sv
// front end: accepts requests, computes the card hash, two-entry queue
`default_nettype none
module alld_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       func_i,
  input  wire logic [7:0]       node_id_i,
  input  wire logic [7:0]       card_hi_i,
  input  wire logic [7:0]       card_lo_i,
  input  wire logic             node_busy_i,
  input  wire logic [7:0]       reported_depth_i,
  input  wire logic             card_in_store_i,
  output logic                  req_valid_o,
  output alld_pkg::req_t        req_o,
  input  wire logic             req_take_i
);

  alld_pkg::req_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign in_stall    = (cnt_q == 2'd2);
  assign push        = in_valid && !in_stall;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_take_i;
  assign req_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{func:           func_i,
                            node_id:        node_id_i,
                            hash:           alld_pkg::card_hash(card_hi_i, card_lo_i),
                            node_busy:      node_busy_i,
                            reported_depth: reported_depth_i,
                            card_in_store:  card_in_store_i};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/alld_back.sv
// back end: slot table, filters, sequential scan and update
`default_nettype none
module alld_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  input  wire alld_pkg::req_t             req_i,
  output logic                            req_take_o,
  input  wire logic [7:0]                 fallback_node_i,
  input  wire logic [3:0]                 miss_penalty_i,
  output logic                            rsp_valid_o,
  output alld_pkg::rsp_t                  rsp_o,
  input  wire logic                       rsp_stall_i
);

  localparam int unsigned N = alld_pkg::MaxSlots;
  localparam int unsigned F = alld_pkg::FilterBits;
  localparam int unsigned SW = alld_pkg::SlotW;
  localparam int unsigned CW = alld_pkg::CountW;
  localparam int unsigned ScW = alld_pkg::ScoreW;

  // slot table (filters reset to zero, cleared per slot on register)
  logic [7:0]   node_q   [N];
  logic [1:0]   st_q     [N];
  logic [7:0]   dep_q    [N];
  logic [F-1:0] filt_q   [N];
  logic [CW-1:0] count_q;

  alld_pkg::exec_state_e state_q, state_d;
  alld_pkg::req_t        req_q;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  have_q, have_d;
  logic [SW-1:0]         best_q, best_d;
  logic [ScW-1:0]        bscore_q, bscore_d;
  logic [7:0]            target_q, target_d;
  logic                  found_q, found_d;
  logic [SW-1:0]         slot_q, slot_d;
  alld_pkg::rsp_t        rsp_q, rsp_d;
  logic                  do_apply;

  logic [SW-1:0]  idx_s;
  logic [ScW-1:0] score;
  logic           hit_idx;
  logic           push_en;
  logic           miss_tgt;

  assign idx_s   = idx_q[SW-1:0];
  assign hit_idx = filt_q[idx_s][req_q.hash];
  assign score   = ScW'(dep_q[idx_s]) + (hit_idx ? '0 : ScW'(miss_penalty_i));
  assign miss_tgt = !found_q || !filt_q[slot_q][req_q.hash];

  assign req_take_o  = (state_q == alld_pkg::ExIdle);
  assign rsp_valid_o = (state_q == alld_pkg::ExOut);
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    have_d   = have_q;
    best_d   = best_q;
    bscore_d = bscore_q;
    target_d = target_q;
    found_d  = found_q;
    slot_d   = slot_q;
    rsp_d    = rsp_q;
    do_apply = 1'b0;
    push_en  = 1'b0;
    case (state_q)
      alld_pkg::ExIdle: begin
        if (req_valid_i) begin
          idx_d   = '0;
          have_d  = 1'b0;
          found_d = 1'b0;
          slot_d  = '0;
          state_d = (req_i.func == alld_pkg::FuncDispatch) ? alld_pkg::ExScan
                                                           : alld_pkg::ExFind;
          target_d = req_i.node_id;
        end
      end
      alld_pkg::ExScan: begin
        if (idx_q >= count_q) begin
          target_d = have_q ? node_q[best_q] : fallback_node_i;
          idx_d    = '0;
          state_d  = alld_pkg::ExFind;
        end else begin
          if (st_q[idx_s] == alld_pkg::StReady && (!have_q || score < bscore_q)) begin
            have_d   = 1'b1;
            best_d   = idx_s;
            bscore_d = score;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      alld_pkg::ExFind: begin
        if (idx_q >= count_q) begin
          state_d = alld_pkg::ExApply;
        end else if (node_q[idx_s] == target_q) begin
          found_d = 1'b1;
          slot_d  = idx_s;
          state_d = alld_pkg::ExApply;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      alld_pkg::ExApply: begin
        do_apply = 1'b1;
        rsp_d = '{dest_node: target_q, card_pushed: 1'b0,
                  slot_found: 1'b0, table_full: 1'b0};
        case (req_q.func)
          alld_pkg::FuncStatus,
          alld_pkg::FuncResult:   rsp_d.slot_found = found_q;
          alld_pkg::FuncDispatch,
          alld_pkg::FuncNak: begin
            rsp_d.slot_found  = found_q;
            push_en           = miss_tgt && req_q.card_in_store;
            rsp_d.card_pushed = push_en;
          end
          alld_pkg::FuncRegister: begin
            rsp_d.slot_found = found_q;
            rsp_d.table_full = !found_q && (count_q >= CW'(N));
          end
          default: ;
        endcase
        state_d = alld_pkg::ExOut;
      end
      alld_pkg::ExOut: begin
        if (!rsp_stall_i) state_d = alld_pkg::ExIdle;
      end
      default: state_d = alld_pkg::ExIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alld_pkg::ExIdle;
      count_q <= '0;
      for (int i = 0; i < N; i++) begin
        st_q[i]   <= alld_pkg::StUnknown;
        dep_q[i]  <= '0;
        filt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (do_apply) begin
        case (req_q.func)
          alld_pkg::FuncStatus: if (found_q) begin
            st_q[slot_q]  <= req_q.node_busy ? alld_pkg::StBusy : alld_pkg::StReady;
            dep_q[slot_q] <= req_q.reported_depth;
          end
          alld_pkg::FuncDispatch: if (found_q && dep_q[slot_q] != 8'hFF)
            dep_q[slot_q] <= dep_q[slot_q] + 8'd1;
          alld_pkg::FuncResult: if (found_q && dep_q[slot_q] != 8'd0)
            dep_q[slot_q] <= dep_q[slot_q] - 8'd1;
          alld_pkg::FuncRegister: if (!found_q && count_q < CW'(N)) begin
            st_q[count_q[SW-1:0]]   <= alld_pkg::StUnknown;
            dep_q[count_q[SW-1:0]]  <= '0;
            filt_q[count_q[SW-1:0]] <= '0;
            count_q <= count_q + 1'b1;
          end
          default: ;
        endcase
        // broadcast sets the card bit in every registered slot's filter
        if (push_en) begin
          for (int i = 0; i < N; i++) begin
            if (CW'(i) < count_q) filt_q[i][req_q.hash] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == alld_pkg::ExIdle && req_valid_i) req_q <= req_i;
    if (do_apply && req_q.func == alld_pkg::FuncRegister && !found_q && count_q < CW'(N))
      node_q[count_q[SW-1:0]] <= req_q.node_id;
    idx_q    <= idx_d;
    have_q   <= have_d;
    best_q   <= best_d;
    bscore_q <= bscore_d;
    target_q <= target_d;
    found_q  <= found_d;
    slot_q   <= slot_d;
    rsp_q    <= rsp_d;
  end

endmodule
`default_nettype wire

>>> hw/rtl/affinity_least_loaded_dispatcher_core.sv
// top level: affinity-aware least-loaded dispatcher
//
// requests enter on in_valid / in_stall with one port per field; a request
// is taken on a rising edge with in_valid high and in_stall low. each request
// gives exactly one result on out_valid / out_stall, in order.
// configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 fallback node, 1 miss penalty); the user must write only while the
// block is idle, as the block does not enforce it. the front end hashes
// the card and holds up to two requests in a queue, so input stays open
// while the back end works or the result waits. the back end walks the
// slot table one slot per cycle, so time is set by the n registered
// slots: a dispatch scans them all for the best score, then searches for
// the target's slot; other requests only search. the back end takes the
// next request only once the result before it has left.
// the result register holds while out_stall is high; the back end then
// waits, and the queue fills before in_stall rises.
// reset clears the slot count, states, depths and all filters at once;
// fallback node resets to 1 and miss penalty to 4.
`default_nettype none
module affinity_least_loaded_dispatcher_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] node_id_i,
  input  wire logic [7:0] card_hi_i,
  input  wire logic [7:0] card_lo_i,
  input  wire logic       node_busy_i,
  input  wire logic [7:0] reported_depth_i,
  input  wire logic       card_in_store_i,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      dest_node_o,
  output logic            card_pushed_o,
  output logic            slot_found_o,
  output logic            table_full_o,
  input  wire logic       cfg_we_i,
  input  wire logic [alld_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [alld_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [7:0] fallback_q;
  logic [3:0] penalty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= 8'd1;
      penalty_q  <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alld_pkg::CfgFallback: fallback_q <= cfg_data_i;
        alld_pkg::CfgPenalty:  penalty_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  alld_pkg::req_t req;
  logic           req_valid, req_take;
  alld_pkg::rsp_t rsp;

  alld_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .func_i, .node_id_i, .card_hi_i, .card_lo_i,
    .node_busy_i, .reported_depth_i, .card_in_store_i,
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_take_i  (req_take)
  );

  alld_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_take_o      (req_take),
    .fallback_node_i (fallback_q),
    .miss_penalty_i  (penalty_q),
    .rsp_valid_o     (out_valid),
    .rsp_o           (rsp),
    .rsp_stall_i     (out_stall)
  );

  assign dest_node_o   = rsp.dest_node;
  assign card_pushed_o = rsp.card_pushed;
  assign slot_found_o  = rsp.slot_found;
  assign table_full_o  = rsp.table_full;

endmodule
`default_nettype wire

>>> tb/tb_affinity_least_loaded_dispatcher_core.sv
// testbench for the affinity least-loaded dispatcher core
`timescale 1ns / 1ps
module tb_affinity_least_loaded_dispatcher_core;
  import alld_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned WatchLimit = 4000;

  typedef struct {
    logic [2:0] func;
    logic [7:0] node_id;
    logic [7:0] card_hi;
    logic [7:0] card_lo;
    logic       node_busy;
    logic [7:0] reported_depth;
    logic       card_in_store;
  } request_t;

  typedef struct {
    logic [7:0] dest_node;
    logic       card_pushed;
    logic       slot_found;
    logic       table_full;
  } outcome_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] func;
  logic [7:0] node_id, card_hi, card_lo, reported_depth;
  logic node_busy, card_in_store;
  logic [7:0] dest_node;
  logic card_pushed, slot_found, table_full;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  affinity_least_loaded_dispatcher_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .func_i(func), .node_id_i(node_id), .card_hi_i(card_hi),
    .card_lo_i(card_lo), .node_busy_i(node_busy),
    .reported_depth_i(reported_depth), .card_in_store_i(card_in_store),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_node_o(dest_node), .card_pushed_o(card_pushed),
    .slot_found_o(slot_found), .table_full_o(table_full),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor copy of the worker table
  logic [7:0]       mdl_node [NumSlots];
  slot_state_e      mdl_state [NumSlots];
  logic [7:0]       mdl_depth [NumSlots];
  logic [FilterBits-1:0] mdl_filter [NumSlots];
  int unsigned      mdl_count;
  logic [7:0]       mdl_fallback;
  logic [3:0]       mdl_penalty;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int unsigned errors;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned find_node(input logic [7:0] n);
    for (int unsigned i = 0; i < mdl_count; i++)
      if (mdl_node[i] == n) return i;
    return NumSlots;
  endfunction

  // push the card to every registered filter unless the target likely holds it or it is not in store
  function automatic logic push_card(input int unsigned s, input int unsigned h,
                                     input logic in_store);
    if (s < NumSlots && mdl_filter[s][h]) return 1'b0;
    if (!in_store) return 1'b0;
    for (int unsigned i = 0; i < mdl_count; i++) mdl_filter[i][h] = 1'b1;
    return 1'b1;
  endfunction

  function automatic outcome_t predict_dispatch(input request_t r);
    outcome_t o;
    int unsigned s, h, best, best_score, score;
    bit have;
    o = '{r.node_id, 1'b0, 1'b0, 1'b0};
    h = (r.card_hi * 31 + r.card_lo) % FilterBits;
    have = 0;
    best = 0;
    best_score = 0;
    case (r.func)
      FuncStatus: begin
        s = find_node(r.node_id);
        if (s < NumSlots) begin
          o.slot_found = 1'b1;
          mdl_state[s] = r.node_busy ? StBusy : StReady;
          mdl_depth[s] = r.reported_depth;
        end
      end
      FuncDispatch: begin
        // lowest score among ready slots, ties to the lowest slot
        for (int unsigned i = 0; i < mdl_count; i++) begin
          if (mdl_state[i] != StReady) continue;
          score = mdl_depth[i] + (mdl_filter[i][h] ? 0 : mdl_penalty);
          if (!have || score < best_score) begin
            have = 1;
            best = i;
            best_score = score;
          end
        end
        o.dest_node = have ? mdl_node[best] : mdl_fallback;
        s = find_node(o.dest_node);
        o.card_pushed = push_card(s, h, r.card_in_store);
        if (s < NumSlots) begin
          o.slot_found = 1'b1;
          if (mdl_depth[s] != 8'hff) mdl_depth[s]++;
        end
      end
      FuncResult: begin
        s = find_node(r.node_id);
        if (s < NumSlots) begin
          o.slot_found = 1'b1;
          if (mdl_depth[s] != 0) mdl_depth[s]--;
        end
      end
      FuncNak: begin
        s = find_node(r.node_id);
        o.slot_found = s < NumSlots;
        o.card_pushed = push_card(s, h, r.card_in_store);
      end
      FuncRegister: begin
        s = find_node(r.node_id);
        if (s < NumSlots) o.slot_found = 1'b1;
        else if (mdl_count >= NumSlots) o.table_full = 1'b1;
        else begin
          mdl_node[mdl_count] = r.node_id;
          mdl_state[mdl_count] = StUnknown;
          mdl_depth[mdl_count] = '0;
          mdl_filter[mdl_count] = '0;
          mdl_count++;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver: one request at a time with a random gap after each
  int unsigned send_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(predict_dispatch(pending_reqs.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if ((in_valid && !in_stall ? pending_reqs.size() > 0
                                            : pending_reqs.size() > 0)) begin
          in_valid <= 1'b1;
          func <= pending_reqs[0].func;
          node_id <= pending_reqs[0].node_id;
          card_hi <= pending_reqs[0].card_hi;
          card_lo <= pending_reqs[0].card_lo;
          node_busy <= pending_reqs[0].node_busy;
          reported_depth <= pending_reqs[0].reported_depth;
          card_in_store <= pending_reqs[0].card_in_store;
          send_gap <= $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall per result, field by field compare
  int unsigned stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        int unsigned hold;
        hold = $urandom_range(0, 4);
        if (expected_outcomes.size() == 0) begin
          report("unexpected result", dest_node, 0);
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          if (dest_node !== e.dest_node) report("dest_node", dest_node, e.dest_node);
          if (card_pushed !== e.card_pushed) report("card_pushed", card_pushed, e.card_pushed);
          if (slot_found !== e.slot_found) report("slot_found", slot_found, e.slot_found);
          if (table_full !== e.table_full) report("table_full", table_full, e.table_full);
        end
        stall_left <= (hold != 0) ? hold - 1 : 0;
        out_stall <= (hold != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic request_t mk_req(input logic [2:0] f, input logic [7:0] n,
      input logic [7:0] ma, input logic [7:0] mi, input logic b, input logic [7:0] d,
      input logic st);
    request_t r;
    r = '{f, n, ma, mi, b, d, st};
    // fields unused by the event are zero
    if (f != FuncStatus) begin r.node_busy = 0; r.reported_depth = 0; end
    if (f != FuncDispatch && f != FuncNak) begin
      r.card_hi = 0; r.card_lo = 0; r.card_in_store = 0;
    end
    if (f == FuncDispatch) r.node_id = 0;
    return r;
  endfunction

  function automatic request_t rand_req(input int unsigned pool);
    logic [2:0] f;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) f = FuncRegister;
    else if (pick < 28) f = FuncStatus;
    else if (pick < 60) f = FuncDispatch;
    else if (pick < 78) f = FuncResult;
    else if (pick < 96) f = FuncNak;
    else f = 3'($urandom_range(5, 7));
    // mostly nodes from a small pool so lookups hit, some strays
    return mk_req(f, ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, pool))
                                                  : 8'($urandom),
                  ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                  8'($urandom), 1'($urandom),
                  ($urandom_range(0, 5) == 0) ? 8'($urandom_range(250, 255))
                                              : 8'($urandom_range(0, 12)),
                  1'($urandom));
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgFallback) mdl_fallback = val;
    else mdl_penalty = val[3:0];
  endtask

  initial begin
    logic [7:0] pen_vals [4];
    pen_vals = '{8'd0, 8'd15, 8'd4, 8'd7};
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    func = '0; node_id = '0; card_hi = '0; card_lo = '0;
    node_busy = 1'b0; reported_depth = '0; card_in_store = 1'b0;
    errors = 0;
    idle_cycles = 0;
    mdl_count = 0;
    mdl_fallback = 8'd1;
    mdl_penalty = 4'd4;
    for (int i = 0; i < NumSlots; i++) begin
      mdl_node[i] = '0; mdl_state[i] = StUnknown; mdl_depth[i] = '0; mdl_filter[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, fallback, registers, extremes
    pending_reqs.push_back(mk_req(FuncDispatch, 0, 255, 255, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncStatus, 1, 0, 0, 0, 5, 0));
    pending_reqs.push_back(mk_req(FuncNak, 9, 0, 0, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncRegister, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncRegister, 255, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncRegister, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncDispatch, 0, 3, 4, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncStatus, 1, 0, 0, 0, 255, 0));
    pending_reqs.push_back(mk_req(FuncStatus, 255, 0, 0, 1, 0, 0));
    pending_reqs.push_back(mk_req(FuncDispatch, 0, 0, 0, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncStatus, 255, 0, 0, 0, 255, 0));
    pending_reqs.push_back(mk_req(FuncDispatch, 0, 0, 0, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncDispatch, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncResult, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncResult, 77, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(FuncNak, 255, 255, 0, 0, 0, 1));
    pending_reqs.push_back(mk_req(FuncNak, 1, 255, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(3'd7, 200, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(3'd5, 0, 0, 0, 0, 0, 0));
    // fill the table, then one more register is rejected
    for (int i = 2; i < 17; i++) pending_reqs.push_back(mk_req(FuncRegister, 8'(i), 0, 0, 0, 0, 0));
    wait_idle();

    // random phases across settings; the table is not reset between phases, so
    // all phases work with the full table left by the directed part
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CfgFallback, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom_range(0, 20)));
      write_cfg(CfgPenalty, pen_vals[ph]);
      for (int k = 0; k < 225; k++) pending_reqs.push_back(rand_req(20));
      wait_idle();
    end
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
